@@ rtl/hcfp_pkg.sv @@
package hcfp_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 16;
  localparam int OUT_CNT_W       = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int HDR_BYTES       = 4;
  localparam int HCNT_W          = 3;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [HCNT_W-1:0] CTRL_HDR_LEN = HCNT_W'(4);
  localparam logic [HCNT_W-1:0] EVT_HDR_LEN  = HCNT_W'(2);

  localparam logic [BYTE_W-1:0] CTRL_TYPE_RST   = BYTE_W'(25);
  localparam logic [BYTE_W-1:0] EVT_TYPE_RST    = BYTE_W'(4);
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = LEN_W'(256);

  typedef enum logic [1:0] {
    REG_CTRL_TYPE   = 2'd0,
    REG_EVT_TYPE    = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ctrl_type;
    logic [BYTE_W-1:0] evt_type;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic                 byte_valid;
    logic [BYTE_W-1:0]    data_out;
    logic                 frame_end;
    logic                 is_event;
    logic [LEN_W-1:0]     opcode;
    logic [BYTE_W-1:0]    event_code;
    logic [LEN_W-1:0]     frame_length;
    logic [OUT_CNT_W-1:0] garbage_count;
    logic [OUT_CNT_W-1:0] dropped_count;
  } res_t;

endpackage

@@ rtl/hci_control_frame_parser_unit.sv @@
// channel   handshake                     payload
// in        in_valid / in_ready           in_rx_byte
// out       out_valid / out_ready         out_byte_valid .. out_dropped_count
// config    psel penable pwrite / pready  paddr pwdata prdata
//
// one request per cycle while in_ready is high: the byte updates the frame
// state and its result is registered at the same edge; the result register
// is the only output stage, and in_ready drops only while it holds a result
// that out_ready has not taken
// synchronous active-low reset returns to hunting, header cleared, counters zero
// configuration returns to type bytes 25 and 4 and a maximum payload of 256
module hci_control_frame_parser_unit
  import hcfp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_byte_valid,
  output logic [BYTE_W-1:0]    out_data_out,
  output logic                 out_frame_end,
  output logic                 out_is_event,
  output logic [LEN_W-1:0]     out_opcode,
  output logic [BYTE_W-1:0]    out_event_code,
  output logic [LEN_W-1:0]     out_frame_length,
  output logic [OUT_CNT_W-1:0] out_garbage_count,
  output logic [OUT_CNT_W-1:0] out_dropped_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic accept;

  hcfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hcfp_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  hcfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accept    (accept),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte_valid    = out_res.byte_valid;
  assign out_data_out      = out_res.data_out;
  assign out_frame_end     = out_res.frame_end;
  assign out_is_event      = out_res.is_event;
  assign out_opcode        = out_res.opcode;
  assign out_event_code    = out_res.event_code;
  assign out_frame_length  = out_res.frame_length;
  assign out_garbage_count = out_res.garbage_count;
  assign out_dropped_count = out_res.dropped_count;

endmodule

@@ rtl/hcfp_cfg_regs.sv @@
module hcfp_cfg_regs
  import hcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_type   <= CTRL_TYPE_RST;
      cfg_r.evt_type    <= EVT_TYPE_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CTRL_TYPE:   cfg_r.ctrl_type   <= pwdata[BYTE_W-1:0];
        REG_EVT_TYPE:    cfg_r.evt_type    <= pwdata[BYTE_W-1:0];
        REG_MAX_PAYLOAD: cfg_r.max_payload <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CTRL_TYPE:   prdata = DATA_W'(cfg_r.ctrl_type);
      REG_EVT_TYPE:    prdata = DATA_W'(cfg_r.evt_type);
      REG_MAX_PAYLOAD: prdata = DATA_W'(cfg_r.max_payload);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/hcfp_parser.sv @@
module hcfp_parser
  import hcfp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output res_t              res
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                  phase_r, phase_nxt;
  logic                    kind_r, kind_nxt;
  logic [HCNT_W-1:0]       hcnt_r, hcnt_nxt;
  logic [BYTE_W-1:0]       hb_r [HDR_BYTES];
  logic [BYTE_W-1:0]       hb_nxt [HDR_BYTES];
  logic [LEN_W-1:0]        plen_r, plen_nxt;
  logic [LEN_W-1:0]        rcnt_r, rcnt_nxt;
  logic                    disc_r, disc_nxt;
  logic [COUNT_WIDTH-1:0]  garb_r, garb_nxt;
  logic [COUNT_WIDTH-1:0]  drop_r, drop_nxt;
  logic                    bvalid, fend;
  logic [BYTE_W-1:0]       bdata;
  logic [HCNT_W-1:0]       need;
  logic [LEN_W-1:0]        hlen;
  logic                    last;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    hcnt_nxt  = hcnt_r;
    hb_nxt    = hb_r;
    plen_nxt  = plen_r;
    rcnt_nxt  = rcnt_r;
    disc_nxt  = disc_r;
    garb_nxt  = garb_r;
    drop_nxt  = drop_r;
    bvalid    = 1'b0;
    bdata     = '0;
    fend      = 1'b0;
    need      = kind_r ? EVT_HDR_LEN : CTRL_HDR_LEN;
    hlen      = kind_r ? LEN_W'(rx_byte) : {rx_byte, hb_r[2]};
    last      = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          hb_nxt[hcnt_r[1:0]] = rx_byte;
          hcnt_nxt = hcnt_r + HCNT_W'(1);
          if (hcnt_nxt >= need) begin
            plen_nxt = hlen;
            rcnt_nxt = '0;
            if (hlen == '0) begin
              fend      = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              disc_nxt  = hlen > cfg.max_payload;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          rcnt_nxt = rcnt_r + LEN_W'(1);
          last     = rcnt_nxt >= plen_r;
          if (!disc_r) begin
            bvalid = 1'b1;
            bdata  = rx_byte;
            fend   = last;
          end
          if (last) begin
            if (disc_r && drop_r != CNT_MAX) begin
              drop_nxt = drop_r + COUNT_WIDTH'(1);
            end
            disc_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (rx_byte == cfg.ctrl_type || rx_byte == cfg.evt_type) begin
            kind_nxt  = rx_byte != cfg.ctrl_type;
            hcnt_nxt  = '0;
            hb_nxt    = '{default: '0};
            plen_nxt  = '0;
            rcnt_nxt  = '0;
            disc_nxt  = 1'b0;
            phase_nxt = PH_HEADER;
          end else if (garb_r != CNT_MAX) begin
            garb_nxt = garb_r + COUNT_WIDTH'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= 1'b0;
      hcnt_r  <= '0;
      hb_r    <= '{default: '0};
      plen_r  <= '0;
      rcnt_r  <= '0;
      disc_r  <= 1'b0;
      garb_r  <= '0;
      drop_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      hcnt_r  <= hcnt_nxt;
      hb_r    <= hb_nxt;
      plen_r  <= plen_nxt;
      rcnt_r  <= rcnt_nxt;
      disc_r  <= disc_nxt;
      garb_r  <= garb_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_comb begin
    res.byte_valid    = bvalid;
    res.data_out      = bdata;
    res.frame_end     = fend;
    res.is_event      = kind_nxt;
    res.opcode        = kind_nxt ? '0 : {hb_nxt[1], hb_nxt[0]};
    res.event_code    = kind_nxt ? hb_nxt[0] : '0;
    res.frame_length  = plen_nxt;
    res.garbage_count = OUT_CNT_W'(garb_nxt);
    res.dropped_count = OUT_CNT_W'(drop_nxt);
  end

`ifndef NO_ASSERTIONS
  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> plen_r != '0 && rcnt_r < plen_r)
    else $error("payload count out of range");

  a_header_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> hcnt_r < (kind_r ? EVT_HDR_LEN : CTRL_HDR_LEN))
    else $error("header count past header length");

  a_discard_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> phase_r == PH_PAYLOAD)
    else $error("discard flag outside payload");

  a_garbage_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_IDLE && rx_byte != cfg.ctrl_type
      && rx_byte != cfg.evt_type && garb_r != CNT_MAX
    |=> garb_r == $past(garb_r) + COUNT_WIDTH'(1))
    else $error("garbage count missed a byte");
`endif

endmodule

@@ rtl/hcfp_out_reg.sv @@
module hcfp_out_reg
  import hcfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic accept,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

endmodule

@@ bench/tb_hci_control_frame_parser_unit.sv @@
module tb_hci_control_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hcfp_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_ready  = 1'b0;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [ADDR_W-1:0]    paddr      = '0;
  logic [DATA_W-1:0]    pwdata     = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic                 out_byte_valid;
  logic [BYTE_W-1:0]    out_data_out;
  logic                 out_frame_end;
  logic                 out_is_event;
  logic [LEN_W-1:0]     out_opcode;
  logic [BYTE_W-1:0]    out_event_code;
  logic [LEN_W-1:0]     out_frame_length;
  logic [OUT_CNT_W-1:0] out_garbage_count;
  logic [OUT_CNT_W-1:0] out_dropped_count;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  always #2 clk = ~clk;

  hci_control_frame_parser_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_valid    (out_byte_valid),
    .out_data_out      (out_data_out),
    .out_frame_end     (out_frame_end),
    .out_is_event      (out_is_event),
    .out_opcode        (out_opcode),
    .out_event_code    (out_event_code),
    .out_frame_length  (out_frame_length),
    .out_garbage_count (out_garbage_count),
    .out_dropped_count (out_dropped_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // deframer state as the block should hold it
  cfg_t                       cfg;
  phase_t                     ph;
  logic                       evt_frame;
  logic [HCNT_W-1:0]          hdr_cnt;
  logic [BYTE_W-1:0]          hdr [HDR_BYTES];
  logic [LEN_W-1:0]           plen;
  logic [LEN_W-1:0]           rcvd;
  logic                       swallow;
  logic [COUNT_WIDTH_DEF-1:0] garbage_total;
  logic [COUNT_WIDTH_DEF-1:0] dropped_total;

  logic [BYTE_W-1:0] pending_bytes [$];
  logic [BYTE_W-1:0] frame_buf [$];
  res_t              expected_results [$];
  res_t              want;
  int                mismatches   = 0;
  int                quiet_cycles = 0;
  int                gap_left     = 0;
  int                stall_left   = 0;
  bit                no_idle      = 1'b0;

  task automatic reset_deframer();
    cfg           = '{CTRL_TYPE_RST, EVT_TYPE_RST, MAX_PAYLOAD_RST};
    ph            = PH_IDLE;
    evt_frame     = 1'b0;
    hdr_cnt       = '0;
    hdr           = '{default: '0};
    plen          = '0;
    rcvd          = '0;
    swallow       = 1'b0;
    garbage_total = '0;
    dropped_total = '0;
  endtask

  function automatic res_t deframe_byte(input logic [BYTE_W-1:0] b);
    res_t              r;
    logic [HCNT_W-1:0] need;
    logic              last;
    r = '0;
    case (ph)
      PH_HEADER: begin
        need = evt_frame ? EVT_HDR_LEN : CTRL_HDR_LEN;
        hdr[hdr_cnt[1:0]] = b;
        hdr_cnt = hdr_cnt + HCNT_W'(1);
        if (hdr_cnt >= need) begin
          plen = evt_frame ? {8'h00, hdr[1]} : {hdr[3], hdr[2]};
          rcvd = '0;
          if (plen == '0) begin
            r.frame_end = 1'b1;
            ph = PH_IDLE;
          end else begin
            swallow = plen > cfg.max_payload;
            ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rcvd = rcvd + LEN_W'(1);
        last = rcvd >= plen;
        if (!swallow) begin
          r.byte_valid = 1'b1;
          r.data_out   = b;
          r.frame_end  = last;
        end
        if (last) begin
          if (swallow && dropped_total != '1)
            dropped_total = dropped_total + COUNT_WIDTH_DEF'(1);
          swallow = 1'b0;
          ph = PH_IDLE;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (b == cfg.ctrl_type || b == cfg.evt_type) begin
          evt_frame = b != cfg.ctrl_type;
          hdr_cnt   = '0;
          hdr       = '{default: '0};
          plen      = '0;
          rcvd      = '0;
          swallow   = 1'b0;
          ph        = PH_HEADER;
        end else if (garbage_total != '1) begin
          garbage_total = garbage_total + COUNT_WIDTH_DEF'(1);
        end
      end
    endcase
    r.is_event      = evt_frame;
    r.opcode        = evt_frame ? '0 : {hdr[1], hdr[0]};
    r.event_code    = evt_frame ? hdr[0] : '0;
    r.frame_length  = plen;
    r.garbage_count = garbage_total[OUT_CNT_W-1:0];
    r.dropped_count = dropped_total[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] garbage_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == cfg.ctrl_type || b == cfg.evt_type);
    return b;
  endfunction

  // frame_buf gets the type byte, header and full payload
  task automatic build_frame(input bit evt, input logic [LEN_W-1:0] op,
                             input logic [LEN_W-1:0] len);
    frame_buf.delete();
    if (evt) begin
      frame_buf.push_back(cfg.evt_type);
      frame_buf.push_back(op[7:0]);
      frame_buf.push_back(len[7:0]);
      len = {8'h00, len[7:0]};
    end else begin
      frame_buf.push_back(cfg.ctrl_type);
      frame_buf.push_back(op[7:0]);
      frame_buf.push_back(op[15:8]);
      frame_buf.push_back(len[7:0]);
      frame_buf.push_back(len[15:8]);
    end
    repeat (int'(len)) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // sends exactly n bytes of frame_buf, padded with random bytes
  task automatic emit_frame(input int n);
    for (int i = 0; i < n; i++)
      pending_bytes.push_back(i < frame_buf.size() ? frame_buf[i]
                                                   : BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic queue_frame(input bit evt, input logic [LEN_W-1:0] op,
                             input logic [LEN_W-1:0] len);
    build_frame(evt, op, len);
    emit_frame(frame_buf.size());
  endtask

  task automatic build_random_frame(input bit split);
    logic [LEN_W-1:0] len;
    len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(13, 40))
                                      : LEN_W'($urandom_range(0, 12));
    build_frame(split && $urandom_range(0, 1), LEN_W'($urandom), len);
  endtask

  // mostly clean frames; broken ones are built so the stream realigns
  task automatic queue_random_traffic(input int n, input bit allow_broken);
    int                start;
    int                k;
    bit                split;
    bit                min_evt;
    logic [BYTE_W-1:0] min_type;
    logic [LEN_W-1:0]  len;
    start    = pending_bytes.size();
    split    = cfg.ctrl_type != cfg.evt_type;
    min_evt  = cfg.evt_type < cfg.ctrl_type;
    min_type = min_evt ? cfg.evt_type : cfg.ctrl_type;
    while (pending_bytes.size() - start < n) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) pending_bytes.push_back(garbage_byte());
        1: if (allow_broken && split && min_type < 8'd64) begin
          // event header cut short: the next frame's type byte becomes its length
          pending_bytes.push_back(cfg.evt_type);
          pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
          build_frame(min_evt, LEN_W'($urandom), LEN_W'($urandom_range(0, 12)));
          emit_frame(int'(min_type) + 1);
        end
        2: if (allow_broken) begin
          // control payload cut short: the next frame is eaten as payload
          len = LEN_W'($urandom_range(2, 20));
          k = $urandom_range(0, int'(len) - 1);
          build_frame(1'b0, LEN_W'($urandom), len);
          emit_frame(5 + k);
          build_random_frame(split);
          emit_frame(int'(len) - k);
        end
        default: begin
          build_random_frame(split);
          emit_frame(frame_buf.size());
        end
      endcase
    end
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CTRL_TYPE:   cfg.ctrl_type   = val[BYTE_W-1:0];
      REG_EVT_TYPE:    cfg.evt_type    = val[BYTE_W-1:0];
      REG_MAX_PAYLOAD: cfg.max_payload = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits of pwdata carry junk that the registers must ignore
  task automatic set_config(input logic [BYTE_W-1:0] ct, input logic [BYTE_W-1:0] et,
                            input logic [LEN_W-1:0] mp);
    cfg_write(REG_CTRL_TYPE,   {24'($urandom), ct});
    cfg_write(REG_EVT_TYPE,    {24'($urandom), et});
    cfg_write(REG_MAX_PAYLOAD, {16'($urandom), mp});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(deframe_byte(in_rx_byte));
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= pending_bytes.pop_front();
        gap_left = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request waiting: data_out %0h", out_data_out);
        end else begin
          want = expected_results.pop_front();
          check_field("byte_valid",    32'(want.byte_valid),    32'(out_byte_valid));
          check_field("data_out",      32'(want.data_out),      32'(out_data_out));
          check_field("frame_end",     32'(want.frame_end),     32'(out_frame_end));
          check_field("is_event",      32'(want.is_event),      32'(out_is_event));
          check_field("opcode",        32'(want.opcode),        32'(out_opcode));
          check_field("event_code",    32'(want.event_code),    32'(out_event_code));
          check_field("frame_length",  32'(want.frame_length),  32'(out_frame_length));
          check_field("garbage_count", want.garbage_count, out_garbage_count);
          check_field("dropped_count", want.dropped_count, out_dropped_count);
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BYTE_W-1:0] ct;
    logic [BYTE_W-1:0] et;
    logic [LEN_W-1:0]  mp;
    reset_deframer();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: garbage extremes, zero-length and short frames of both kinds
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    queue_frame(1'b0, 16'hFFFF, 16'd0);
    queue_frame(1'b1, 16'h00FF, 16'd0);
    queue_frame(1'b1, 16'h0000, 16'd1);
    queue_frame(1'b0, 16'h0000, 16'd2);
    drain();

    // equal type bytes start a control frame; max of zero drops all but empty frames
    set_config(8'h55, 8'h55, 16'd0);
    queue_frame(1'b0, 16'h1234, 16'd1);
    queue_frame(1'b0, 16'hA5C3, 16'd0);
    drain();

    // length just past the max through the high length byte, swallowed
    no_idle = 1'b1;
    set_config(8'h00, 8'hFF, 16'h00FF);
    queue_frame(1'b0, 16'h8001, 16'h0100);
    drain();
    no_idle = 1'b0;

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(8'h00, 8'hFF, 16'd0);
        1: set_config(8'hFF, 8'h00, 16'hFFFF);
        default: begin
          ct = BYTE_W'($urandom_range(0, 255));
          et = ($urandom_range(0, 3) == 0) ? ct : BYTE_W'($urandom_range(0, 255));
          case ($urandom_range(0, 3))
            0: mp = '0;
            1: mp = LEN_W'($urandom_range(0, 16));
            2: mp = 16'hFFFF;
            default: mp = LEN_W'($urandom_range(0, 65535));
          endcase
          set_config(ct, et, mp);
        end
      endcase
      no_idle = (p == 3);
      queue_random_traffic(30, p >= 2);
      drain();
    end
    no_idle = 1'b0;

    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hcfp_pkg.sv
rtl/hcfp_cfg_regs.sv
rtl/hcfp_parser.sv
rtl/hcfp_out_reg.sv
rtl/hci_control_frame_parser_unit.sv
bench/tb_hci_control_frame_parser_unit.sv
